[hw/rtl/i2cm_pkg.sv]
// ----------------------------------------------------------------------------
// I2C register access master package
// Shared types and fixed codes for the tick channel, result channel and
// configuration registers.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // Commands carried with a tick.
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Configuration register indexes (byte address = 4 * index).
  localparam logic [1:0] REG_DEV_ADDR   = 2'd0;
  localparam logic [1:0] REG_START_IDLE = 2'd1;
  localparam logic [1:0] REG_SHORT_PH   = 2'd2;
  localparam logic [1:0] REG_LOW_PH     = 2'd3;

  // Register reset values.
  localparam logic [7:0] DEV_ADDR_RST   = 8'h44;
  localparam logic [7:0] START_IDLE_RST = 8'd4;
  localparam logic [3:0] SHORT_PH_RST   = 4'd1;
  localparam logic [3:0] LOW_PH_RST     = 4'd2;

  // Address byte handling: bit 0 carries the read/write flag.
  localparam logic [7:0] DEV_WR_MASK = 8'hfe;
  localparam logic [7:0] DEV_RD_BIT  = 8'h01;

  // Bytes held by the 32-bit data fields.
  localparam int DATA_BYTES = 4;

  typedef struct packed {
    logic [7:0] device_address;
    logic [7:0] start_idle_ticks;
    logic [3:0] short_phase_ticks;
    logic [3:0] low_phase_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  reg_pointer;
    logic [31:0] write_data;
    logic [2:0]  byte_count;
    logic        sda_in;
  } item_t;

  typedef struct packed {
    logic        scl_level;
    logic        sda_level;
    logic        sda_enable;
    logic        busy_res;
    logic        done_res;
    logic        ack_error;
    logic [31:0] read_data;
  } result_t;

endpackage

[hw/rtl/i2cm_in_if.sv]
// ----------------------------------------------------------------------------
// I2C master tick channel
// Valid/ready channel that carries one tick with its optional request.
// ----------------------------------------------------------------------------
interface i2cm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  reg_pointer;
  logic [31:0] write_data;
  logic [2:0]  byte_count;
  logic        sda_in;

  modport source (
    output valid, command, reg_pointer, write_data, byte_count, sda_in,
    input  ready
  );
  modport sink (
    input  valid, command, reg_pointer, write_data, byte_count, sda_in,
    output ready
  );
endinterface

[hw/rtl/i2cm_out_if.sv]
// ----------------------------------------------------------------------------
// I2C master result channel
// Valid/ready channel that carries pin levels and status for one tick.
// ----------------------------------------------------------------------------
interface i2cm_out_if;
  logic        valid;
  logic        ready;
  logic        scl_level;
  logic        sda_level;
  logic        sda_enable;
  logic        busy_res;
  logic        done_res;
  logic        ack_error;
  logic [31:0] read_data;

  modport source (
    output valid, scl_level, sda_level, sda_enable, busy_res, done_res, ack_error,
           read_data,
    input  ready
  );
  modport sink (
    input  valid, scl_level, sda_level, sda_enable, busy_res, done_res, ack_error,
           read_data,
    output ready
  );
endinterface

[hw/rtl/i2cm_seq.sv]
// ----------------------------------------------------------------------------
// I2C master bus sequencer
// Holds the transaction state and advances it by one tick per step.
// ----------------------------------------------------------------------------
module i2cm_seq #(
  parameter int MAX_BYTES = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  i2cm_pkg::item_t   item_i,
  input  i2cm_pkg::cfg_t    cfg_i,
  output i2cm_pkg::result_t res_o
);

  localparam int BIDX_W = $clog2(MAX_BYTES + 3);
  localparam int CNT_W  = $clog2(MAX_BYTES + 1);

  localparam logic [4:0] PH_IDLE     = 5'd0;
  localparam logic [4:0] PH_ST_IDLE  = 5'd1;
  localparam logic [4:0] PH_ST_HOLD  = 5'd2;
  localparam logic [4:0] PH_ST_LOW   = 5'd3;
  localparam logic [4:0] PH_WB_SETUP = 5'd4;
  localparam logic [4:0] PH_WB_HIGH  = 5'd5;
  localparam logic [4:0] PH_WB_LOW   = 5'd6;
  localparam logic [4:0] PH_AK_SETUP = 5'd7;
  localparam logic [4:0] PH_AK_HIGH  = 5'd8;
  localparam logic [4:0] PH_AK_LOW   = 5'd9;
  localparam logic [4:0] PH_RS_HIGH  = 5'd10;
  localparam logic [4:0] PH_RS_HOLD  = 5'd11;
  localparam logic [4:0] PH_RS_LOW   = 5'd12;
  localparam logic [4:0] PH_RD_HIGH  = 5'd13;
  localparam logic [4:0] PH_RD_LOW   = 5'd14;
  localparam logic [4:0] PH_MA_SETUP = 5'd15;
  localparam logic [4:0] PH_MA_HIGH  = 5'd16;
  localparam logic [4:0] PH_MA_LOW   = 5'd17;
  localparam logic [4:0] PH_STOP     = 5'd18;
  localparam logic [4:0] PH_ABORT    = 5'd19;

  logic [4:0]        phase_q, phase_d;
  logic [7:0]        tick_q, tick_d;
  logic [2:0]        bit_q, bit_d;
  logic [BIDX_W-1:0] byte_q, byte_d;
  logic [7:0]        shift_q, shift_d;
  logic [31:0]       rbuf_q, rbuf_d;
  logic [31:0]       wbuf_q, wbuf_d;
  logic [7:0]        ptr_q, ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              rmode_q, rmode_d;

  logic [4:0]        cur_ph;
  logic [7:0]        ph_len;
  logic              scl, sda, sda_en, done, err, nack;
  logic [BIDX_W-1:0] byte_nx;

  // Byte sent at a given position of a write: address, pointer, then data.
  function automatic logic [7:0] out_byte(input logic [BIDX_W-1:0] idx,
                                          input logic [7:0] dev,
                                          input logic [7:0] ptr,
                                          input logic [31:0] wbuf);
    logic [7:0] r;
    r = '0;
    if (int'(idx) == 0) begin
      r = dev & i2cm_pkg::DEV_WR_MASK;
    end else if (int'(idx) == 1) begin
      r = ptr;
    end else begin
      for (int k = 0; k < i2cm_pkg::DATA_BYTES; k++) begin
        if (int'(idx) == k + 2) r = wbuf[8*k +: 8];
      end
    end
    return r;
  endfunction

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    bit_d   = bit_q;
    byte_d  = byte_q;
    shift_d = shift_q;
    rbuf_d  = rbuf_q;
    wbuf_d  = wbuf_q;
    ptr_d   = ptr_q;
    cnt_d   = cnt_q;
    rmode_d = rmode_q;
    scl     = 1'b1;
    sda     = 1'b1;
    sda_en  = 1'b0;
    done    = 1'b0;
    err     = 1'b0;
    nack    = 1'b0;
    ph_len  = 8'd1;
    byte_nx = '0;
    cur_ph  = PH_IDLE;

    if (step_i) begin
      if (phase_q == PH_IDLE &&
          (item_i.command == i2cm_pkg::CMD_WRITE || item_i.command == i2cm_pkg::CMD_READ)) begin
        ptr_d   = item_i.reg_pointer;
        wbuf_d  = item_i.write_data;
        if (int'(item_i.byte_count) > MAX_BYTES) begin
          cnt_d = CNT_W'(MAX_BYTES);
        end else begin
          cnt_d = CNT_W'(item_i.byte_count);
        end
        rmode_d = (item_i.command == i2cm_pkg::CMD_READ);
        rbuf_d  = '0;
        byte_d  = '0;
        bit_d   = '0;
        shift_d = '0;
        tick_d  = '0;
        phase_d = PH_ST_IDLE;
      end

      cur_ph = phase_d;
      nack   = (int'(byte_d) + 1 >= int'(cnt_d));

      if (cur_ph != PH_IDLE) begin
        // Pin levels driven during this tick.
        case (cur_ph)
          PH_ST_IDLE, PH_RS_HIGH: begin
            scl = 1'b1; sda = 1'b1; sda_en = 1'b1;
          end
          PH_ST_HOLD, PH_RS_HOLD, PH_STOP: begin
            scl = 1'b1; sda = 1'b0; sda_en = 1'b1;
          end
          PH_ST_LOW, PH_RS_LOW: begin
            scl = 1'b0; sda = 1'b0; sda_en = 1'b1;
          end
          PH_WB_SETUP, PH_WB_LOW: begin
            scl = 1'b0; sda = shift_d[7]; sda_en = 1'b1;
          end
          PH_WB_HIGH: begin
            scl = 1'b1; sda = shift_d[7]; sda_en = 1'b1;
          end
          PH_AK_SETUP, PH_AK_LOW, PH_RD_LOW: begin
            scl = 1'b0; sda = 1'b1; sda_en = 1'b0;
          end
          PH_MA_SETUP, PH_MA_LOW: begin
            scl = 1'b0; sda = nack; sda_en = 1'b1;
          end
          PH_MA_HIGH: begin
            scl = 1'b1; sda = nack; sda_en = 1'b1;
          end
          default: begin
            scl = 1'b1; sda = 1'b1; sda_en = 1'b0;
          end
        endcase

        case (cur_ph)
          PH_ST_IDLE: begin
            ph_len = (cfg_i.start_idle_ticks == 8'd0) ? 8'd1 : cfg_i.start_idle_ticks;
          end
          PH_ST_LOW, PH_WB_LOW, PH_AK_LOW, PH_RS_LOW, PH_RD_LOW, PH_MA_LOW: begin
            ph_len = (cfg_i.low_phase_ticks == 4'd0) ? 8'd1 : {4'd0, cfg_i.low_phase_ticks};
          end
          default: begin
            ph_len = (cfg_i.short_phase_ticks == 4'd0) ? 8'd1 :
                     {4'd0, cfg_i.short_phase_ticks};
          end
        endcase

        if ({1'b0, tick_d} + 9'd1 >= {1'b0, ph_len}) begin
          tick_d = '0;
          unique case (cur_ph)
            PH_ST_IDLE: phase_d = PH_ST_HOLD;
            PH_ST_HOLD: phase_d = PH_ST_LOW;
            PH_ST_LOW: begin
              shift_d = out_byte('0, cfg_i.device_address, ptr_d, wbuf_d);
              bit_d   = '0;
              phase_d = PH_WB_SETUP;
            end
            PH_WB_SETUP: phase_d = PH_WB_HIGH;
            PH_WB_HIGH:  phase_d = PH_WB_LOW;
            PH_WB_LOW: begin
              shift_d = {shift_d[6:0], 1'b0};
              phase_d = (bit_d == 3'd7) ? PH_AK_SETUP : PH_WB_SETUP;
              bit_d   = bit_d + 3'd1;
            end
            PH_AK_SETUP: phase_d = PH_AK_HIGH;
            PH_AK_HIGH:  phase_d = item_i.sda_in ? PH_ABORT : PH_AK_LOW;
            PH_AK_LOW: begin
              if (!rmode_d) begin
                byte_nx = byte_d + BIDX_W'(1);
                byte_d  = byte_nx;
                if (int'(byte_nx) < 2 + int'(cnt_d)) begin
                  shift_d = out_byte(byte_nx, cfg_i.device_address, ptr_d, wbuf_d);
                  bit_d   = '0;
                  phase_d = PH_WB_SETUP;
                end else begin
                  phase_d = PH_STOP;
                end
              end else if (int'(byte_d) == 0) begin
                byte_d  = BIDX_W'(1);
                shift_d = ptr_d;
                bit_d   = '0;
                phase_d = PH_WB_SETUP;
              end else if (int'(byte_d) == 1) begin
                byte_d  = BIDX_W'(2);
                phase_d = PH_RS_HIGH;
              end else begin
                byte_d  = '0;
                bit_d   = '0;
                shift_d = '0;
                phase_d = (int'(cnt_d) == 0) ? PH_STOP : PH_RD_HIGH;
              end
            end
            PH_RS_HIGH: phase_d = PH_RS_HOLD;
            PH_RS_HOLD: phase_d = PH_RS_LOW;
            PH_RS_LOW: begin
              shift_d = cfg_i.device_address | i2cm_pkg::DEV_RD_BIT;
              bit_d   = '0;
              phase_d = PH_WB_SETUP;
            end
            PH_RD_HIGH: begin
              shift_d = {shift_d[6:0], item_i.sda_in};
              phase_d = PH_RD_LOW;
            end
            PH_RD_LOW: begin
              if (bit_d == 3'd7) begin
                // Bytes past the 32-bit read field are dropped.
                for (int k = 0; k < i2cm_pkg::DATA_BYTES; k++) begin
                  if (int'(byte_d) == k) rbuf_d[8*k +: 8] = rbuf_d[8*k +: 8] | shift_d;
                end
                phase_d = PH_MA_SETUP;
              end else begin
                phase_d = PH_RD_HIGH;
              end
              bit_d = bit_d + 3'd1;
            end
            PH_MA_SETUP: phase_d = PH_MA_HIGH;
            PH_MA_HIGH:  phase_d = PH_MA_LOW;
            PH_MA_LOW: begin
              byte_nx = byte_d + BIDX_W'(1);
              byte_d  = byte_nx;
              if (int'(byte_nx) < int'(cnt_d)) begin
                bit_d   = '0;
                shift_d = '0;
                phase_d = PH_RD_HIGH;
              end else begin
                phase_d = PH_STOP;
              end
            end
            PH_STOP: begin
              phase_d = PH_IDLE;
              done    = 1'b1;
            end
            PH_ABORT: begin
              phase_d = PH_IDLE;
              done    = 1'b1;
              err     = 1'b1;
            end
            default: phase_d = PH_IDLE;
          endcase
        end else begin
          tick_d = tick_d + 8'd1;
        end
      end
    end
  end

  always_comb begin
    res_o.scl_level  = scl;
    res_o.sda_level  = sda;
    res_o.sda_enable = sda_en;
    res_o.busy_res   = (phase_d != PH_IDLE);
    res_o.done_res   = done;
    res_o.ack_error  = done & err;
    res_o.read_data  = done ? rbuf_d : 32'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      bit_q   <= '0;
      byte_q  <= '0;
      shift_q <= '0;
      rbuf_q  <= '0;
      wbuf_q  <= '0;
      ptr_q   <= '0;
      cnt_q   <= '0;
      rmode_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      byte_q  <= byte_d;
      shift_q <= shift_d;
      rbuf_q  <= rbuf_d;
      wbuf_q  <= wbuf_d;
      ptr_q   <= ptr_d;
      cnt_q   <= cnt_d;
      rmode_q <= rmode_d;
    end
  end

endmodule

[hw/rtl/i2c_register_access_master.sv]
// ----------------------------------------------------------------------------
// I2C register access master
// Tick-driven I2C master that runs register write and read transactions.
// ----------------------------------------------------------------------------
// Each beat on the input channel is one bus timing tick. A tick may carry a
// write or read request; a request is taken only while no transaction runs,
// and that tick becomes the first tick of the idle-high lead-in. Every tick
// also carries the sampled SDA level.
// Every accepted tick produces exactly one result beat with the pin levels
// driven during that tick, the busy flag, and on the last tick of a
// transaction the done pulse, the ACK error flag and the bytes read.
// The result of a tick is registered and presented in the cycle after the
// tick is accepted. Throughput is one tick per cycle while the receiver
// does not stall, set by the single sequencer step before the result register.
// When the receiver stalls, the result register holds its beat and the input
// channel accepts a new tick only in a cycle where the held beat is taken.
// Reset puts the sequencer in idle with SCL high and SDA released, empties
// the result register and restores configuration defaults. The user writes
// configuration over the APB port only while idle; the block does not check.
// ----------------------------------------------------------------------------
module i2c_register_access_master #(
  parameter int MAX_BYTES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  i2cm_in_if.sink     in_i,
  i2cm_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers.
  logic [7:0] dev_addr_q;
  logic [7:0] start_idle_q;
  logic [3:0] short_ph_q;
  logic [3:0] low_ph_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q   <= i2cm_pkg::DEV_ADDR_RST;
      start_idle_q <= i2cm_pkg::START_IDLE_RST;
      short_ph_q   <= i2cm_pkg::SHORT_PH_RST;
      low_ph_q     <= i2cm_pkg::LOW_PH_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        i2cm_pkg::REG_DEV_ADDR:   dev_addr_q   <= pwdata[7:0];
        i2cm_pkg::REG_START_IDLE: start_idle_q <= pwdata[7:0];
        i2cm_pkg::REG_SHORT_PH:   short_ph_q   <= pwdata[3:0];
        i2cm_pkg::REG_LOW_PH:     low_ph_q     <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read data is returned in the access cycle of a read.
  always_comb begin
    unique case (paddr[3:2])
      i2cm_pkg::REG_DEV_ADDR:   prdata = {24'd0, dev_addr_q};
      i2cm_pkg::REG_START_IDLE: prdata = {24'd0, start_idle_q};
      i2cm_pkg::REG_SHORT_PH:   prdata = {28'd0, short_ph_q};
      i2cm_pkg::REG_LOW_PH:     prdata = {28'd0, low_ph_q};
      default:                  prdata = 32'd0;
    endcase
  end

  i2cm_pkg::cfg_t    cfg;
  i2cm_pkg::item_t   item;
  i2cm_pkg::result_t res;

  assign cfg.device_address    = dev_addr_q;
  assign cfg.start_idle_ticks  = start_idle_q;
  assign cfg.short_phase_ticks = short_ph_q;
  assign cfg.low_phase_ticks   = low_ph_q;

  assign item.command     = in_i.command;
  assign item.reg_pointer = in_i.reg_pointer;
  assign item.write_data  = in_i.write_data;
  assign item.byte_count  = in_i.byte_count;
  assign item.sda_in      = in_i.sda_in;

  // Handshake: a tick is taken whenever the result register is free or is
  // being emptied in this cycle.
  logic              out_valid_q;
  logic              in_ready;
  logic              in_fire;
  i2cm_pkg::result_t res_q;

  assign in_ready   = ~out_valid_q | out_o.ready;
  assign in_fire    = in_i.valid & in_ready;
  assign in_i.ready = in_ready;

  // The sequencer advances its state only on an accepted tick.
  i2cm_seq #(
    .MAX_BYTES(MAX_BYTES)
  ) u_seq (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(in_fire),
    .item_i(item),
    .cfg_i (cfg),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload needs no reset; it is qualified by the valid flag.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.scl_level  = res_q.scl_level;
  assign out_o.sda_level  = res_q.sda_level;
  assign out_o.sda_enable = res_q.sda_enable;
  assign out_o.busy_res   = res_q.busy_res;
  assign out_o.done_res   = res_q.done_res;
  assign out_o.ack_error  = res_q.ack_error;
  assign out_o.read_data  = res_q.read_data;

`ifndef SYNTHESIS
  // A held result must block the input channel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("tick accepted while result beat is stalled");

  // Every accepted tick leaves a result beat behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> out_valid_q)
    else $error("accepted tick produced no result beat");

  // An ACK error is only reported on the tick a transaction ends.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_o.ack_error) |-> (out_o.done_res && !out_o.busy_res))
    else $error("ack error reported outside a done beat");
`endif

endmodule

[sim/tb_i2c_register_access_master.sv]
// ----------------------------------------------------------------------------
// Testbench for the I2C register access master
// Streams bus timing ticks into the block, predicts the pin levels and status
// of every tick with a cycle-free model of the bus sequencer, and compares
// each result beat with the prediction while both channels idle at random.
// ----------------------------------------------------------------------------
module tb_i2c_register_access_master;

  localparam int         MAX_XFER      = 4;
  // The command field is two bits wide; the fourth code is a plain tick.
  localparam logic [1:0] CMD_SPARE     = 2'd3;
  localparam int         NO_NACK       = -1;
  localparam int         REPORT_LIMIT  = 10;
  localparam int         RANDOM_TICKS  = 240;
  localparam int         RANDOM_BLOCKS = 3;

  // Sequencer phases of the predictor, in bus order.
  typedef enum logic [4:0] {
    P_IDLE, P_LEAD, P_START_HOLD, P_START_LOW,
    P_BIT_SETUP, P_BIT_HIGH, P_BIT_LOW,
    P_ACK_SETUP, P_ACK_HIGH, P_ACK_LOW,
    P_RS_HIGH, P_RS_HOLD, P_RS_LOW,
    P_RD_HIGH, P_RD_LOW,
    P_MACK_SETUP, P_MACK_HIGH, P_MACK_LOW,
    P_STOP, P_ABORT
  } bus_phase_e;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  i2cm_in_if  in_bus ();
  i2cm_out_if out_bus ();

  i2c_register_access_master #(
    .MAX_BYTES(MAX_XFER)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // --------------------------------------------------------------------------
  // Predictor state. It mirrors the block's registers and sequencer and is
  // advanced once for every tick beat that the block accepts.
  // --------------------------------------------------------------------------
  i2cm_pkg::cfg_t    bus_cfg;
  bus_phase_e        bus_phase;
  int                tick_cnt;
  int                bit_idx;
  int                byte_idx;
  int                cnt_hold;
  logic [7:0]        shifter;
  logic [7:0]        ptr_hold;
  logic [31:0]       rd_buf;
  logic [31:0]       wr_buf;
  logic              is_read;

  i2cm_pkg::result_t expected_ticks[$];
  int                ticks_sent = 0;
  int                fail_count = 0;
  // When clear, neither side inserts idle cycles.
  bit                gaps_on = 1'b1;

  // A zero in a timing register behaves as a one-tick phase.
  function automatic int phase_len(bus_phase_e p);
    int n;
    case (p)
      P_LEAD: n = bus_cfg.start_idle_ticks;
      P_START_LOW, P_BIT_LOW, P_ACK_LOW, P_RS_LOW, P_RD_LOW, P_MACK_LOW:
        n = bus_cfg.low_phase_ticks;
      default: n = bus_cfg.short_phase_ticks;
    endcase
    return (n == 0) ? 1 : n;
  endfunction

  // Pin levels driven during a phase, packed as {sda_enable, sda, scl}.
  // Whenever SDA is released its level reads as one.
  function automatic logic [2:0] drive_levels(bus_phase_e p);
    logic master_nack;
    master_nack = (byte_idx + 1 >= cnt_hold);
    case (p)
      P_LEAD, P_RS_HIGH:                   return 3'b111;
      P_START_HOLD, P_RS_HOLD, P_STOP:     return 3'b101;
      P_START_LOW, P_RS_LOW:               return 3'b100;
      P_BIT_SETUP, P_BIT_LOW:              return {1'b1, shifter[7], 1'b0};
      P_BIT_HIGH:                          return {1'b1, shifter[7], 1'b1};
      P_ACK_SETUP, P_ACK_LOW, P_RD_LOW:    return 3'b010;
      P_MACK_SETUP, P_MACK_LOW:            return {1'b1, master_nack, 1'b0};
      P_MACK_HIGH:                         return {1'b1, master_nack, 1'b1};
      default:                             return 3'b011;
    endcase
  endfunction

  // Byte sent at a position of a write: address, pointer, then data bytes.
  function automatic logic [7:0] out_byte(int idx);
    if (idx == 0) return bus_cfg.device_address & i2cm_pkg::DEV_WR_MASK;
    if (idx == 1) return ptr_hold;
    return 8'(wr_buf >> (8 * (idx - 2)));
  endfunction

  task automatic load_byte(input logic [7:0] value);
    shifter   = value;
    bit_idx   = 0;
    bus_phase = P_BIT_SETUP;
  endtask

  // One tick of the sequencer: take a request if idle, drive the pins of the
  // current phase, then move on when the phase has run its length.
  task automatic advance_bus(input i2cm_pkg::item_t it, output i2cm_pkg::result_t r);
    logic [2:0] lv;
    logic       finished;
    logic       aborted;
    finished = 1'b0;
    aborted  = 1'b0;
    lv       = 3'b011;
    if (bus_phase == P_IDLE &&
        (it.command == i2cm_pkg::CMD_WRITE || it.command == i2cm_pkg::CMD_READ)) begin
      ptr_hold  = it.reg_pointer;
      wr_buf    = it.write_data;
      cnt_hold  = (it.byte_count > MAX_XFER) ? MAX_XFER : int'(it.byte_count);
      is_read   = (it.command == i2cm_pkg::CMD_READ);
      rd_buf    = '0;
      byte_idx  = 0;
      bit_idx   = 0;
      shifter   = '0;
      tick_cnt  = 0;
      bus_phase = P_LEAD;
    end
    if (bus_phase != P_IDLE) begin
      lv = drive_levels(bus_phase);
      tick_cnt++;
      if (tick_cnt >= phase_len(bus_phase)) begin
        tick_cnt = 0;
        case (bus_phase)
          P_LEAD:       bus_phase = P_START_HOLD;
          P_START_HOLD: bus_phase = P_START_LOW;
          P_START_LOW:  load_byte(out_byte(0));
          P_BIT_SETUP:  bus_phase = P_BIT_HIGH;
          P_BIT_HIGH:   bus_phase = P_BIT_LOW;
          P_BIT_LOW: begin
            shifter = {shifter[6:0], 1'b0};
            bit_idx++;
            if (bit_idx >= 8) bus_phase = P_ACK_SETUP;
            else bus_phase = P_BIT_SETUP;
          end
          P_ACK_SETUP: bus_phase = P_ACK_HIGH;
          P_ACK_HIGH: begin
            if (it.sda_in) bus_phase = P_ABORT;
            else bus_phase = P_ACK_LOW;
          end
          P_ACK_LOW: begin
            if (!is_read) begin
              byte_idx++;
              if (byte_idx < 2 + cnt_hold) load_byte(out_byte(byte_idx));
              else bus_phase = P_STOP;
            end else if (byte_idx == 0) begin
              byte_idx = 1;
              load_byte(out_byte(1));
            end else if (byte_idx == 1) begin
              byte_idx  = 2;
              bus_phase = P_RS_HIGH;
            end else begin
              // The read address was taken; clock in the data bytes.
              byte_idx = 0;
              bit_idx  = 0;
              shifter  = '0;
              if (cnt_hold == 0) bus_phase = P_STOP;
              else bus_phase = P_RD_HIGH;
            end
          end
          P_RS_HIGH: bus_phase = P_RS_HOLD;
          P_RS_HOLD: bus_phase = P_RS_LOW;
          P_RS_LOW:  load_byte(bus_cfg.device_address | i2cm_pkg::DEV_RD_BIT);
          P_RD_HIGH: begin
            shifter   = {shifter[6:0], it.sda_in};
            bus_phase = P_RD_LOW;
          end
          P_RD_LOW: begin
            bit_idx++;
            if (bit_idx >= 8) begin
              rd_buf    = rd_buf | (32'(shifter) << (8 * byte_idx));
              bus_phase = P_MACK_SETUP;
            end else begin
              bus_phase = P_RD_HIGH;
            end
          end
          P_MACK_SETUP: bus_phase = P_MACK_HIGH;
          P_MACK_HIGH:  bus_phase = P_MACK_LOW;
          P_MACK_LOW: begin
            byte_idx++;
            if (byte_idx < cnt_hold) begin
              bit_idx   = 0;
              shifter   = '0;
              bus_phase = P_RD_HIGH;
            end else begin
              bus_phase = P_STOP;
            end
          end
          P_STOP: begin
            bus_phase = P_IDLE;
            finished  = 1'b1;
          end
          P_ABORT: begin
            bus_phase = P_IDLE;
            finished  = 1'b1;
            aborted   = 1'b1;
          end
          default: bus_phase = P_IDLE;
        endcase
      end
    end
    r.scl_level  = lv[0];
    r.sda_level  = lv[1];
    r.sda_enable = lv[2];
    r.busy_res   = (bus_phase != P_IDLE);
    r.done_res   = finished;
    r.ack_error  = aborted;
    r.read_data  = finished ? rd_buf : '0;
  endtask

  // --------------------------------------------------------------------------
  // Clock, watchdog and the receiving side.
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // The slowest legal run stays far below this bound, even with every beat
  // waiting out the longest idle on both sides.
  initial begin
    #3_000_000;
    $display("tb_i2c_register_access_master: done, errors");
    $finish;
  end

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("%0t: %s", $time, msg);
  endtask

  // The receiver draws a stall before every result beat, then holds ready
  // until that beat is taken.
  initial begin
    int stall;
    out_bus.ready = 1'b0;
    forever begin
      stall = gaps_on ? $urandom_range(0, 6) : 0;
      repeat (stall) begin
        @(negedge clk_i);
        out_bus.ready <= 1'b0;
      end
      @(negedge clk_i);
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_bus.valid && out_bus.ready));
    end
  end

  // Every result beat is compared, field by field, with the oldest
  // prediction still waiting.
  always @(posedge clk_i) begin
    i2cm_pkg::result_t got;
    i2cm_pkg::result_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got.scl_level  = out_bus.scl_level;
      got.sda_level  = out_bus.sda_level;
      got.sda_enable = out_bus.sda_enable;
      got.busy_res   = out_bus.busy_res;
      got.done_res   = out_bus.done_res;
      got.ack_error  = out_bus.ack_error;
      got.read_data  = out_bus.read_data;
      if (expected_ticks.size() == 0) begin
        note_failure("result beat arrived with no tick outstanding");
      end else begin
        want = expected_ticks.pop_front();
        if (got.scl_level !== want.scl_level || got.sda_level !== want.sda_level ||
            got.sda_enable !== want.sda_enable || got.busy_res !== want.busy_res ||
            got.done_res !== want.done_res || got.ack_error !== want.ack_error ||
            got.read_data !== want.read_data)
          note_failure($sformatf({"tick mismatch: expected scl=%b sda=%b en=%b busy=%b ",
            "done=%b err=%b data=%h, got scl=%b sda=%b en=%b busy=%b done=%b err=%b ",
            "data=%h"},
            want.scl_level, want.sda_level, want.sda_enable, want.busy_res,
            want.done_res, want.ack_error, want.read_data,
            got.scl_level, got.sda_level, got.sda_enable, got.busy_res,
            got.done_res, got.ack_error, got.read_data));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sending side and configuration port.
  // --------------------------------------------------------------------------

  // Sends one tick beat after a random gap and predicts its result once the
  // block has taken it. Valid stays high so that the next beat may follow
  // back to back; drain_results lowers it before any pause.
  task automatic send_tick(input i2cm_pkg::item_t it);
    i2cm_pkg::result_t exp;
    int                gap;
    gap = gaps_on ? $urandom_range(0, 6) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_bus.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_bus.valid       <= 1'b1;
    in_bus.command     <= it.command;
    in_bus.reg_pointer <= it.reg_pointer;
    in_bus.write_data  <= it.write_data;
    in_bus.byte_count  <= it.byte_count;
    in_bus.sda_in      <= it.sda_in;
    do @(posedge clk_i); while (!(in_bus.valid && in_bus.ready));
    advance_bus(it, exp);
    expected_ticks.push_back(exp);
    ticks_sent++;
  endtask

  function automatic i2cm_pkg::item_t random_item();
    i2cm_pkg::item_t it;
    it.command     = 2'($urandom_range(0, 3));
    it.reg_pointer = 8'($urandom);
    it.write_data  = $urandom;
    it.byte_count  = 3'($urandom_range(0, 7));
    it.sda_in      = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // A tick with no request; the other fields are random noise.
  task automatic idle_tick(input logic [1:0] cmd, input logic sda);
    i2cm_pkg::item_t it;
    it         = random_item();
    it.command = cmd;
    it.sda_in  = sda;
    send_tick(it);
  endtask

  // Stops sending and waits until every predicted beat has come back.
  task automatic drain_results();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [1:0] idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes a register, mirrors it in the predictor and reads it back.
  task automatic write_register(input logic [1:0] idx, input logic [7:0] value);
    logic [31:0] back;
    logic [31:0] mask;
    apb_access(1'b1, idx, {24'b0, value}, back);
    case (idx)
      i2cm_pkg::REG_DEV_ADDR:   bus_cfg.device_address    = value;
      i2cm_pkg::REG_START_IDLE: bus_cfg.start_idle_ticks  = value;
      i2cm_pkg::REG_SHORT_PH:   bus_cfg.short_phase_ticks = value[3:0];
      i2cm_pkg::REG_LOW_PH:     bus_cfg.low_phase_ticks   = value[3:0];
      default: ;
    endcase
    mask = (idx == i2cm_pkg::REG_SHORT_PH || idx == i2cm_pkg::REG_LOW_PH) ?
           32'h0000_000f : 32'h0000_00ff;
    apb_access(1'b0, idx, '0, back);
    if (((back ^ {24'b0, value}) & mask) != 0)
      note_failure($sformatf("register %0d reads back %h, expected %h", idx, back, value));
  endtask

  // Registers change only while the bus is idle and nothing is in flight.
  task automatic apply_settings(input logic [7:0] dev, input logic [7:0] lead,
                                input logic [3:0] short_len, input logic [3:0] low_len);
    while (bus_phase != P_IDLE) idle_tick(i2cm_pkg::CMD_TICK, 1'b0);
    drain_results();
    write_register(i2cm_pkg::REG_DEV_ADDR, dev);
    write_register(i2cm_pkg::REG_START_IDLE, lead);
    write_register(i2cm_pkg::REG_SHORT_PH, {4'b0, short_len});
    write_register(i2cm_pkg::REG_LOW_PH, {4'b0, low_len});
  endtask

  // Runs one bus transaction from the request tick to the tick after which
  // the sequencer is idle again. The slave acknowledges every byte except the
  // one numbered nack_at (counted from zero); all other ticks carry random
  // SDA levels, which become the read data, and random ignored requests.
  task automatic run_transaction(input logic [1:0] cmd, input logic [7:0] ptr,
                                 input logic [31:0] data, input logic [2:0] cnt,
                                 input int nack_at);
    i2cm_pkg::item_t it;
    int              acks;
    it             = random_item();
    it.command     = cmd;
    it.reg_pointer = ptr;
    it.write_data  = data;
    it.byte_count  = cnt;
    send_tick(it);
    acks = 0;
    while (bus_phase != P_IDLE) begin
      it = random_item();
      // Only the SDA level of the last tick of an ACK clock is sampled.
      if (bus_phase == P_ACK_HIGH && tick_cnt + 1 >= phase_len(bus_phase)) begin
        it.sda_in = (acks == nack_at);
        acks++;
      end
      send_tick(it);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Plain ticks and two transactions under the reset values of the registers.
  task automatic test_reset_defaults();
    idle_tick(i2cm_pkg::CMD_TICK, 1'b0);
    idle_tick(CMD_SPARE, 1'b1);
    idle_tick(i2cm_pkg::CMD_TICK, 1'b1);
    run_transaction(i2cm_pkg::CMD_WRITE, 8'h12, 32'h8765_4321, 3'd1, NO_NACK);
    run_transaction(i2cm_pkg::CMD_READ, 8'h34, $urandom, 3'd1, NO_NACK);
  endtask

  // Shortest phases, field extremes, saturated counts, an empty read and
  // every place where a missing ACK can abort a transaction.
  task automatic test_special_cases();
    apply_settings(8'h5a, 8'd1, 4'd1, 4'd1);
    run_transaction(i2cm_pkg::CMD_WRITE, 8'hff, 32'hffff_ffff, 3'd7, NO_NACK);
    // An empty read sends the address with the read bit and then stops.
    run_transaction(i2cm_pkg::CMD_READ, 8'h00, 32'h0000_0000, 3'd0, NO_NACK);
    run_transaction(i2cm_pkg::CMD_READ, 8'hff, $urandom, 3'd7, NO_NACK);
    run_transaction(i2cm_pkg::CMD_WRITE, 8'($urandom), $urandom, 3'd1, 0);
    run_transaction(i2cm_pkg::CMD_WRITE, 8'($urandom), $urandom, 3'd1, 1);
    run_transaction(i2cm_pkg::CMD_WRITE, 8'($urandom), $urandom, 3'd1, 2);
    run_transaction(i2cm_pkg::CMD_READ, 8'($urandom), $urandom, 3'd1, 2);
    idle_tick(CMD_SPARE, 1'b0);
  endtask

  // Longest and zero phase settings. The longest setting is cut short by a
  // missing ACK on the address byte and runs without idle cycles.
  task automatic test_register_settings();
    gaps_on = 1'b0;
    apply_settings(8'hff, 8'd255, 4'd15, 4'd15);
    run_transaction(i2cm_pkg::CMD_WRITE, 8'($urandom), $urandom, 3'd1, 0);
    gaps_on = 1'b1;
    apply_settings(8'h00, 8'd0, 4'd0, 4'd0);
    run_transaction(i2cm_pkg::CMD_WRITE, 8'h00, 32'h0000_0000, 3'd0, NO_NACK);
    run_transaction(i2cm_pkg::CMD_READ, 8'($urandom), $urandom, 3'd1, NO_NACK);
  endtask

  // Mostly complete transactions with random content and settings, some
  // aborted by a missing ACK, mixed with stray idle ticks. Each block starts
  // with a full drain and a new register setting.
  task automatic test_random_traffic();
    int   stop_at;
    logic [1:0] cmd;
    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      apply_settings(8'($urandom), 8'($urandom_range(0, 8)),
                     4'($urandom_range(0, 2)), 4'($urandom_range(0, 2)));
      stop_at = ticks_sent + RANDOM_TICKS / RANDOM_BLOCKS;
      while (ticks_sent < stop_at) begin
        gaps_on = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 6) == 0) begin
          repeat ($urandom_range(1, 5))
            idle_tick($urandom_range(0, 1) ? CMD_SPARE : i2cm_pkg::CMD_TICK,
                      1'($urandom_range(0, 1)));
        end else begin
          cmd = $urandom_range(0, 1) ? i2cm_pkg::CMD_READ : i2cm_pkg::CMD_WRITE;
          run_transaction(cmd, 8'($urandom), $urandom, 3'($urandom_range(0, 7)),
                          ($urandom_range(0, 7) == 0) ? $urandom_range(0, 5) : NO_NACK);
        end
      end
    end
    gaps_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    rst_ni             = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.command     = i2cm_pkg::CMD_TICK;
    in_bus.reg_pointer = '0;
    in_bus.write_data  = '0;
    in_bus.byte_count  = '0;
    in_bus.sda_in      = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;

    // The predictor starts from the reset state of the block.
    bus_cfg.device_address    = i2cm_pkg::DEV_ADDR_RST;
    bus_cfg.start_idle_ticks  = i2cm_pkg::START_IDLE_RST;
    bus_cfg.short_phase_ticks = i2cm_pkg::SHORT_PH_RST;
    bus_cfg.low_phase_ticks   = i2cm_pkg::LOW_PH_RST;
    bus_phase = P_IDLE;
    tick_cnt  = 0;
    bit_idx   = 0;
    byte_idx  = 0;
    cnt_hold  = 0;
    shifter   = '0;
    ptr_hold  = '0;
    rd_buf    = '0;
    wr_buf    = '0;
    is_read   = 1'b0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_special_cases();
    test_register_settings();
    test_random_traffic();

    // Wait for the last beats, then a few more cycles to catch strays.
    drain_results();
    repeat (8) @(posedge clk_i);
    fail_count += expected_ticks.size();
    if (fail_count == 0)
      $display("tb_i2c_register_access_master: done, clean");
    else
      $display("tb_i2c_register_access_master: done, errors");
    $finish;
  end

endmodule
